[src/resp_command_parser_assert.svh]
// Assertion macros for the RESP parser
`ifndef RESP_COMMAND_PARSER_ASSERT_SVH
`define RESP_COMMAND_PARSER_ASSERT_SVH
`define RCP_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RCP_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[src/rcp_pkg.sv]
`default_nettype none
package rcp_pkg;
    localparam int STACK_DEPTH = 8;
    localparam int SL_W = $clog2(STACK_DEPTH + 1);
    localparam int SI_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    localparam logic [1:0] CFG_MAX_ARRAY = 2'd0;
    localparam logic [1:0] CFG_MAX_STRING = 2'd1;
    localparam logic [1:0] CFG_MAX_LINE = 2'd2;

    localparam logic [32:0] MAG_LIMIT = 33'h1_0000_0000 >> 1;
    localparam logic [31:0] NO_LENGTH = 32'hFFFF_FFFF;

    typedef enum logic [1:0]
    {
        K_PAYLOAD = 2'd0,
        K_ACCEPT = 2'd1,
        K_COMPLETE = 2'd2,
        K_ERROR = 2'd3
    } kind_t;

    typedef enum logic [2:0]
    {
        M_IDLE,
        M_ARRAY,
        M_STRHDR,
        M_INT,
        M_DATA
    } mode_t;

    typedef struct packed
    {
        logic is_cr;
        logic is_digit;
        logic is_minus;
        logic is_star;
        logic is_dollar;
        logic is_colon;
        logic [3:0] digit;
        logic [7:0] value;
    } cls_t;
endpackage
`default_nettype wire

[src/rcp_front.sv]
`default_nettype none
module rcp_front
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic valid_in,
    output logic stall_in,
    input wire logic [7:0] in_byte,
    output logic q_valid,
    input wire logic q_stall,
    output rcp_pkg::cls_t q_item
);
    import rcp_pkg::*;

    // two-entry queue of classified bytes
    cls_t mem_reg [2];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cls_t c;
    logic push, pop;

    always_comb
    begin
        c.value = in_byte;
        c.is_cr = (in_byte == CH_CR);
        c.is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
        c.is_minus = (in_byte == CH_MINUS);
        c.is_star = (in_byte == CH_STAR);
        c.is_dollar = (in_byte == CH_DOLLAR);
        c.is_colon = (in_byte == CH_COLON);
        c.digit = 4'(in_byte - CH_0);
    end

    assign stall_in = (cnt_reg == 2'd2);
    assign push = valid_in && !stall_in;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && !q_stall;
    assign q_item = mem_reg[rp_reg];
    assign wp_next = wp_reg ^ push;
    assign rp_next = rp_reg ^ pop;
    assign cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

[src/rcp_back.sv]
`default_nettype none
module rcp_back
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic q_valid,
    output logic q_stall,
    input wire rcp_pkg::cls_t q_item,
    input wire logic [10:0] max_array_count,
    input wire logic [29:0] max_string_length,
    input wire logic [12:0] max_line_length,
    output logic valid,
    input wire logic stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic signed [31:0] code,
    output logic [29:0] string_length,
    output logic err_o
);
    import rcp_pkg::*;

    logic err_reg, err_next;
    mode_t mode_reg, mode_next;
    logic acr_reg, acr_next;
    logic [32:0] acc_reg, acc_next;
    logic sign_reg, sign_next, dig_reg, dig_next, bad_reg, bad_next;
    logic [12:0] lc_reg, lc_next;
    logic [10:0] el_reg, el_next;
    logic [31:0] exp_reg, exp_next;
    logic [10:0] stk_reg [STACK_DEPTH];
    logic [SL_W-1:0] sl_reg, sl_next;
    logic [31:0] lcode_reg, lcode_next;
    logic [29:0] llen_reg, llen_next;
    logic ov_reg, ov_next;
    logic [1:0] okind_reg, okind_next;
    logic [7:0] odata_reg, odata_next;
    logic push_w;
    logic [10:0] push_val;

    logic take, emit;
    logic [1:0] ekind;
    logic [7:0] edata;
    logic [35:0] acc10;
    logic num_ok, num_neg;
    logic [31:0] num_val;
    logic [10:0] el_dec;
    logic ed_complete;

    assign q_stall = ov_reg && stall;
    assign take = q_valid && !q_stall;
    assign err_o = err_reg;

    assign acc10 = {3'b0, acc_reg} * 36'd10 + {32'b0, q_item.digit};
    assign num_ok = !bad_reg && dig_reg &&
        (sign_reg ? (acc_reg <= MAG_LIMIT) : (acc_reg < MAG_LIMIT));
    assign num_neg = sign_reg && (acc_reg != 33'd0);
    assign num_val = sign_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
    assign el_dec = (el_reg != 11'd0) ? (el_reg - 11'd1) : 11'd0;
    assign ed_complete = (el_dec == 11'd0) && (sl_reg == '0);

    always_comb
    begin
        err_next = err_reg; mode_next = mode_reg; acr_next = acr_reg;
        acc_next = acc_reg; sign_next = sign_reg; dig_next = dig_reg;
        bad_next = bad_reg; lc_next = lc_reg; el_next = el_reg;
        exp_next = exp_reg; sl_next = sl_reg; lcode_next = lcode_reg;
        llen_next = llen_reg; push_w = 1'b0; push_val = el_dec;
        emit = 1'b0; ekind = K_ERROR; edata = 8'd0;
        if (!take)
        begin
        end
        else if (err_reg)
        begin
            emit = 1'b1;
        end
        else if (acr_reg)
        begin
            acr_next = 1'b0;
        end
        else if (!q_item.is_cr)
        begin
            if (lc_reg >= max_line_length)
            begin
                emit = 1'b1; err_next = 1'b1;
            end
            else if (mode_reg == M_IDLE)
            begin
                lc_next = 13'd1; acc_next = '0;
                sign_next = 1'b0; dig_next = 1'b0; bad_next = 1'b0;
                if (q_item.is_star)
                begin
                    mode_next = M_ARRAY;
                    if (el_reg != 11'd0)
                    begin
                        el_next = el_dec;
                        if (el_dec != 11'd0)
                        begin
                            if (sl_reg >= SL_W'(STACK_DEPTH))
                            begin
                                emit = 1'b1; err_next = 1'b1;
                            end
                            else
                            begin
                                push_w = 1'b1;
                                sl_next = sl_reg + 1'b1;
                                el_next = '0;
                            end
                        end
                    end
                end
                else if (q_item.is_dollar) mode_next = M_STRHDR;
                else if (q_item.is_colon) mode_next = M_INT;
                else
                begin
                    emit = 1'b1; err_next = 1'b1;
                end
            end
            else if (mode_reg == M_DATA)
            begin
                lc_next = lc_reg + 13'd1;
                emit = 1'b1; ekind = K_PAYLOAD; edata = q_item.value;
            end
            else
            begin
                lc_next = lc_reg + 13'd1;
                if (q_item.is_digit)
                begin
                    dig_next = 1'b1;
                    if (acc10 > {3'b0, MAG_LIMIT})
                    begin
                        bad_next = 1'b1; acc_next = MAG_LIMIT + 33'd1;
                    end
                    else acc_next = acc10[32:0];
                end
                else if (q_item.is_minus && lc_reg == 13'd1) sign_next = 1'b1;
                else bad_next = 1'b1;
            end
        end
        else
        begin
            acr_next = 1'b1;
            if (mode_reg == M_IDLE)
            begin
                emit = 1'b1; err_next = 1'b1;
            end
            else if (mode_reg == M_DATA)
            begin
                if ({19'd0, lc_reg} != exp_reg)
                begin
                    emit = 1'b1; err_next = 1'b1;
                end
                else
                begin
                    llen_next = {17'd0, lc_reg};
                    lc_next = '0;
                    emit = 1'b1;
                    if (ed_complete)
                    begin
                        ekind = K_COMPLETE; el_next = '0; exp_next = NO_LENGTH;
                        sl_next = '0; mode_next = M_IDLE;
                    end
                    else
                    begin
                        ekind = K_ACCEPT; exp_next = NO_LENGTH; mode_next = M_IDLE;
                        if (el_dec == 11'd0)
                        begin
                            sl_next = sl_reg - 1'b1;
                            el_next = stk_reg[SI_W'(sl_reg - 1'b1)];
                        end
                        else el_next = el_dec;
                    end
                end
            end
            else
            begin
                lc_next = '0;
                if (!num_ok)
                begin
                    emit = 1'b1; err_next = 1'b1;
                end
                else if (mode_reg == M_ARRAY)
                begin
                    if (num_neg || acc_reg > {22'd0, max_array_count})
                    begin
                        emit = 1'b1; err_next = 1'b1;
                    end
                    else if (acc_reg[10:0] == 11'd0)
                    begin
                        emit = 1'b1; ekind = K_COMPLETE; el_next = '0;
                        exp_next = NO_LENGTH; sl_next = '0; mode_next = M_IDLE;
                    end
                    else
                    begin
                        el_next = acc_reg[10:0]; mode_next = M_IDLE;
                    end
                end
                else if (mode_reg == M_STRHDR)
                begin
                    if (!num_neg && acc_reg > {3'd0, max_string_length})
                    begin
                        emit = 1'b1; err_next = 1'b1;
                    end
                    else if (num_val == NO_LENGTH)
                    begin
                        emit = 1'b1; ekind = K_COMPLETE; el_next = '0;
                        exp_next = NO_LENGTH; sl_next = '0; mode_next = M_IDLE;
                    end
                    else
                    begin
                        exp_next = num_val; mode_next = M_DATA;
                    end
                end
                else
                begin
                    lcode_next = num_val;
                    mode_next = M_IDLE;
                    if (ed_complete)
                    begin
                        emit = 1'b1; ekind = K_COMPLETE; el_next = '0;
                        exp_next = NO_LENGTH; sl_next = '0;
                    end
                    else if (el_dec == 11'd0)
                    begin
                        sl_next = sl_reg - 1'b1;
                        el_next = stk_reg[SI_W'(sl_reg - 1'b1)];
                    end
                    else el_next = el_dec;
                end
            end
        end
    end

    assign ov_next = emit || (ov_reg && stall);
    assign okind_next = emit ? ekind : okind_reg;
    assign odata_next = emit ? edata : odata_reg;

    assign valid = ov_reg;
    assign kind = okind_reg;
    assign data_byte = odata_reg;
    assign code = lcode_reg;
    assign string_length = llen_reg;
    // code/length hold while a result waits, as no item is taken then

    always_ff @(posedge clk)
    begin
        if (push_w)
        begin
            stk_reg[SI_W'(sl_reg)] <= push_val;
        end
        okind_reg <= okind_next;
        odata_reg <= odata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0; mode_reg <= M_IDLE; acr_reg <= 1'b0;
            acc_reg <= '0; sign_reg <= 1'b0; dig_reg <= 1'b0; bad_reg <= 1'b0;
            lc_reg <= '0; el_reg <= '0; exp_reg <= NO_LENGTH; sl_reg <= '0;
            lcode_reg <= '0; llen_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            err_reg <= err_next; mode_reg <= mode_next; acr_reg <= acr_next;
            acc_reg <= acc_next; sign_reg <= sign_next; dig_reg <= dig_next;
            bad_reg <= bad_next; lc_reg <= lc_next; el_reg <= el_next;
            exp_reg <= exp_next; sl_reg <= sl_next; lcode_reg <= lcode_next;
            llen_reg <= llen_next; ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

[src/resp_command_parser.sv]
// An accepted byte is registered in the front queue; the back end registers its result.
// Throughput: one byte per cycle while the output is not stalled.
// A two-entry queue between front and back absorbs a stalled output.
// Reset (asynchronous, rst_n low) clears parser state and restores register defaults.
// The array count stack holds no reset value; entries are read only after a push.
`default_nettype none
module resp_command_parser
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic valid_in,
    output logic stall_in,
    input wire logic [7:0] in_byte,
    output logic valid,
    input wire logic stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic signed [31:0] code,
    output logic [29:0] string_length,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [1:0] cfg_index,
    input wire logic [29:0] cfg_data
);
    import rcp_pkg::*;

    logic q_valid, q_stall, err;
    cls_t q_item;
    logic [10:0] mac_reg;
    logic [29:0] msl_reg;
    logic [12:0] mll_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg <= 11'd1024;
            msl_reg <= 30'd536870912;
            mll_reg <= 13'd4096;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_ARRAY: mac_reg <= cfg_data[10:0];
                CFG_MAX_STRING: msl_reg <= cfg_data;
                CFG_MAX_LINE: mll_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    rcp_front u_front
    (
        .clk(clk), .rst_n(rst_n), .valid_in(valid_in), .stall_in(stall_in),
        .in_byte(in_byte), .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item)
    );

    rcp_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_stall(q_stall),
        .q_item(q_item), .max_array_count(mac_reg), .max_string_length(msl_reg),
        .max_line_length(mll_reg), .valid(valid), .stall(stall), .kind(kind),
        .data_byte(data_byte), .code(code), .string_length(string_length),
        .err_o(err)
    );

`include "resp_command_parser_assert.svh"
    `RCP_ASSERT_NEXT(a_err_sticky, err, err)
    `RCP_ASSERT_IMPL(a_err_kind, err && valid && $past(err), kind == K_ERROR)
endmodule
`default_nettype wire
